### rtl/core/rvoc_pkg.sv
package rvoc_pkg;

    localparam int CMD_W    = 3;
    localparam int VER_W    = 4;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 2;

    localparam logic [CMD_W-1:0] CMD_READ         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ_STAMP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_CHECK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE_INSERT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE_CHECK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COMMIT       = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ABORT        = 3'd6;

    localparam logic [STATUS_W-1:0] RES_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] RES_WAIT  = 3'd1;
    localparam logic [STATUS_W-1:0] RES_ABORT = 3'd2;
    localparam logic [STATUS_W-1:0] RES_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] RES_BAD   = 3'd4;

    localparam logic [ENTRY_W-1:0] ST_COMMITTED = 2'd0;
    localparam logic [ENTRY_W-1:0] ST_PENDING   = 2'd1;
    localparam logic [ENTRY_W-1:0] ST_ABORTED   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_CHECK,
        S_RESP
    } seq_state_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

    typedef struct packed {
        logic status_we;
        logic wtime_we;
        logic rtime_we;
    } wr_ctrl_t;

endpackage

### rtl/core/rvoc_cmp.sv
module rvoc_cmp
    import rvoc_pkg::*;
#(
    parameter int TIME_BITS = 48
)
(
    input  logic [TIME_BITS-1:0] a,
    input  logic [TIME_BITS-1:0] b,
    output cmp_res_t             res
);

    assign res.lt = (a < b);
    assign res.eq = (a == b);

endmodule

### rtl/core/rvoc_store.sv
module rvoc_store
    import rvoc_pkg::*;
#(
    parameter int MAX_VERSIONS = 16,
    parameter int TIME_BITS    = 48
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [$clog2(MAX_VERSIONS)-1:0] rd_addr,
    output logic [ENTRY_W-1:0]              rd_status,
    output logic [TIME_BITS-1:0]            rd_wtime,
    output logic [TIME_BITS-1:0]            rd_rtime,
    input  wr_ctrl_t                        wr_ctrl,
    input  logic [$clog2(MAX_VERSIONS)-1:0] wr_addr,
    input  logic [ENTRY_W-1:0]              wr_status,
    input  logic [TIME_BITS-1:0]            wr_time
);

    localparam int IDX_W = $clog2(MAX_VERSIONS);

    logic [ENTRY_W-1:0]   mem_status [MAX_VERSIONS];
    logic [TIME_BITS-1:0] mem_wtime  [MAX_VERSIONS];
    logic [TIME_BITS-1:0] mem_rtime  [MAX_VERSIONS];

    logic [ENTRY_W-1:0]   status_q_reg;
    logic [TIME_BITS-1:0] wtime_q_reg;
    logic [TIME_BITS-1:0] rtime_q_reg;
    logic                 zero_q_reg;
    logic [TIME_BITS-1:0] rt0_reg;
    logic [TIME_BITS-1:0] rt0_next;
    logic                 wr_zero;

    assign wr_zero = (wr_addr == IDX_W'(0));

    always_ff @(posedge clk)
    begin
        if (wr_ctrl.status_we)
        begin
            mem_status[wr_addr] <= wr_status;
        end
        if (wr_ctrl.wtime_we)
        begin
            mem_wtime[wr_addr] <= wr_time;
        end
        if (wr_ctrl.rtime_we)
        begin
            mem_rtime[wr_addr] <= wr_time;
        end
        status_q_reg <= mem_status[rd_addr];
        wtime_q_reg  <= mem_wtime[rd_addr];
        rtime_q_reg  <= mem_rtime[rd_addr];
        zero_q_reg   <= (rd_addr == IDX_W'(0));
    end

    always_comb
    begin
        rt0_next = rt0_reg;
        if (wr_ctrl.rtime_we && wr_zero)
        begin
            rt0_next = wr_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt0_reg <= '0;
        end
        else
        begin
            rt0_reg <= rt0_next;
        end
    end

    assign rd_status = zero_q_reg ? ST_COMMITTED : status_q_reg;
    assign rd_wtime  = zero_q_reg ? '0 : wtime_q_reg;
    assign rd_rtime  = zero_q_reg ? rt0_reg : rtime_q_reg;

endmodule

### rtl/core/rvoc_seq.sv
module rvoc_seq
    import rvoc_pkg::*;
#(
    parameter int MAX_VERSIONS = 16,
    parameter int TIME_BITS    = 48
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [CMD_W-1:0]                in_cmd,
    input  logic [TIME_BITS-1:0]            in_time,
    input  logic [VER_W-1:0]                in_ver,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [STATUS_W-1:0]             out_status,
    output logic [VER_W-1:0]                out_ver,
    output logic [$clog2(MAX_VERSIONS)-1:0] rd_addr,
    input  logic [ENTRY_W-1:0]              rd_status,
    input  logic [TIME_BITS-1:0]            rd_wtime,
    input  logic [TIME_BITS-1:0]            rd_rtime,
    output wr_ctrl_t                        wr_ctrl,
    output logic [$clog2(MAX_VERSIONS)-1:0] wr_addr,
    output logic [ENTRY_W-1:0]              wr_status,
    output logic [TIME_BITS-1:0]            wr_time,
    output logic [TIME_BITS-1:0]            cmp_a,
    output logic [TIME_BITS-1:0]            cmp_b,
    input  cmp_res_t                        cmp_res
);

    localparam int IDX_W = $clog2(MAX_VERSIONS);
    localparam int CNT_W = $clog2(MAX_VERSIONS + 1);
    localparam int CMP_W = (CNT_W > VER_W) ? CNT_W : VER_W;

    seq_state_t           state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [VER_W-1:0]     ver_reg, ver_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     fetch_addr_reg, fetch_addr_next;
    logic [STATUS_W-1:0]  res_reg, res_next;
    logic [VER_W-1:0]     vout_reg, vout_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [VER_W-1:0]     m_ver_reg, m_ver_next;

    logic [CNT_W-1:0]     head_full;
    logic [IDX_W-1:0]     head;
    logic [CMP_W-1:0]     in_ver_ext;
    logic [CMP_W-1:0]     ver_ext;
    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     chk_ext;
    logic                 in_id_ok;
    logic                 not_above;
    logic                 scan_hit;
    logic                 head_match;
    logic                 table_full;
    logic                 out_free;

    assign head_full  = count_reg - CNT_W'(1);
    assign head       = head_full[IDX_W-1:0];
    assign in_ver_ext = CMP_W'(in_ver);
    assign ver_ext    = CMP_W'(ver_reg);
    assign count_ext  = CMP_W'(count_reg);
    assign chk_ext    = CMP_W'(chk_idx_reg);
    assign in_id_ok   = (in_ver_ext < count_ext);
    assign not_above  = cmp_res.lt || cmp_res.eq;
    assign scan_hit   = chk_vld_reg && (rd_status != ST_ABORTED)
                        && ((cmd_reg == CMD_WRITE_INSERT) || not_above);
    assign head_match = (rd_status == ST_PENDING) && cmp_res.eq;
    assign table_full = (count_reg == CNT_W'(MAX_VERSIONS));
    assign out_free   = !m_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        time_next       = time_reg;
        ver_next        = ver_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        fetch_addr_next = fetch_addr_reg;
        res_next        = res_reg;
        vout_next       = vout_reg;
        m_valid_next    = m_valid_reg && !out_ready;
        m_status_next   = m_status_reg;
        m_ver_next      = m_ver_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = in_cmd;
                    time_next     = in_time;
                    ver_next      = in_ver;
                    scan_idx_next = head;
                    chk_vld_next  = 1'b0;
                    res_next      = RES_OK;
                    vout_next     = '0;
                    case (in_cmd)
                        CMD_READ, CMD_WRITE_CHECK:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_READ_CHECK, CMD_WRITE_INSERT:
                        begin
                            if (in_id_ok)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                res_next   = RES_BAD;
                                state_next = S_RESP;
                            end
                        end
                        CMD_READ_STAMP:
                        begin
                            if (in_id_ok)
                            begin
                                fetch_addr_next = in_ver_ext[IDX_W-1:0];
                                state_next      = S_FETCH;
                            end
                            else
                            begin
                                res_next   = RES_BAD;
                                state_next = S_RESP;
                            end
                        end
                        CMD_COMMIT, CMD_ABORT:
                        begin
                            fetch_addr_next = head;
                            state_next      = S_FETCH;
                        end
                        default:
                        begin
                            res_next   = RES_BAD;
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                chk_idx_next  = scan_idx_reg;
                chk_vld_next  = 1'b1;
                scan_idx_next = scan_idx_reg - IDX_W'(1);
                if (scan_hit)
                begin
                    state_next = S_RESP;
                    case (cmd_reg)
                        CMD_READ:
                        begin
                            if (rd_status == ST_PENDING)
                            begin
                                res_next = RES_WAIT;
                            end
                            else
                            begin
                                vout_next = chk_ext[VER_W-1:0];
                            end
                        end
                        CMD_READ_CHECK:
                        begin
                            if (chk_ext != ver_ext)
                            begin
                                res_next = RES_ABORT;
                            end
                        end
                        CMD_WRITE_INSERT:
                        begin
                            if (chk_ext > ver_ext)
                            begin
                                res_next = RES_ABORT;
                            end
                            else
                            begin
                                fetch_addr_next = ver_ext[IDX_W-1:0];
                                state_next      = S_FETCH;
                            end
                        end
                        default:
                        begin
                            fetch_addr_next = chk_idx_reg;
                            state_next      = S_FETCH;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_RESP;
                case (cmd_reg)
                    CMD_WRITE_INSERT:
                    begin
                        if (!not_above)
                        begin
                            res_next = RES_ABORT;
                        end
                        else if (table_full)
                        begin
                            res_next = RES_FULL;
                        end
                        else
                        begin
                            vout_next  = count_ext[VER_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_WRITE_CHECK:
                    begin
                        if (!not_above)
                        begin
                            res_next = RES_ABORT;
                        end
                    end
                    CMD_COMMIT:
                    begin
                        if (!head_match)
                        begin
                            res_next = RES_BAD;
                        end
                    end
                    default:
                    begin
                        res_next = RES_OK;
                    end
                endcase
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                    m_ver_next    = vout_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        rd_addr   = fetch_addr_reg;
        cmp_a     = rd_wtime;
        cmp_b     = time_reg;
        wr_ctrl   = '0;
        wr_addr   = fetch_addr_reg;
        wr_status = ST_PENDING;
        wr_time   = time_reg;
        unique case (state_reg)
            S_SCAN:
            begin
                rd_addr = scan_idx_reg;
            end
            S_CHECK:
            begin
                case (cmd_reg)
                    CMD_READ_STAMP:
                    begin
                        cmp_a            = rd_rtime;
                        wr_ctrl.rtime_we = cmp_res.lt;
                    end
                    CMD_WRITE_INSERT:
                    begin
                        cmp_a             = rd_rtime;
                        wr_addr           = count_reg[IDX_W-1:0];
                        wr_ctrl.status_we = not_above && !table_full;
                        wr_ctrl.wtime_we  = not_above && !table_full;
                        wr_ctrl.rtime_we  = not_above && !table_full;
                    end
                    CMD_COMMIT:
                    begin
                        wr_status         = ST_COMMITTED;
                        wr_ctrl.status_we = head_match;
                    end
                    CMD_ABORT:
                    begin
                        wr_status         = ST_ABORTED;
                        wr_ctrl.status_we = head_match;
                    end
                    default:
                    begin
                        cmp_a = rd_rtime;
                    end
                endcase
            end
            default:
            begin
                rd_addr = fetch_addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= CNT_W'(1);
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        time_reg       <= time_next;
        ver_reg        <= ver_next;
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        fetch_addr_reg <= fetch_addr_next;
        res_reg        <= res_next;
        vout_reg       <= vout_next;
        m_status_reg   <= m_status_next;
        m_ver_reg      <= m_ver_next;
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_ver    = m_ver_reg;

endmodule

### rtl/core/row_version_order_checker.sv
// Channel | Dir | Handshake          | Payload
// s       | in  | s_tvalid, s_tready | cmd, txn_time, version_in
// m       | out | m_tvalid, m_tready | status, version_out
//
// One command at a time. Commands that search the version list walk it
// newest first, one entry per cycle through the single read port of the
// entry memory. Read stamp, commit and abort skip the scan (fetch, check,
// respond); a bad id or code goes straight to the response state.
// Reset leaves entry 0 committed with zero timestamps, with no clearing pass.
// A result waits in the output register while the next command is accepted.
module row_version_order_checker
    import rvoc_pkg::*;
#(
    parameter int MAX_VERSIONS = 16,
    parameter int TIME_BITS    = 48
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // cmd, txn_time, version_in
    input  logic [((CMD_W+TIME_BITS+VER_W+7)/8)*8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // status, version_out
    output logic [7:0]                             m_tdata
);

    localparam int IDX_W = $clog2(MAX_VERSIONS);

    logic [CMD_W-1:0]     in_cmd;
    logic [TIME_BITS-1:0] in_time;
    logic [VER_W-1:0]     in_ver;
    logic [STATUS_W-1:0]  out_status;
    logic [VER_W-1:0]     out_ver;
    logic [IDX_W-1:0]     rd_addr;
    logic [ENTRY_W-1:0]   rd_status;
    logic [TIME_BITS-1:0] rd_wtime;
    logic [TIME_BITS-1:0] rd_rtime;
    wr_ctrl_t             wr_ctrl;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_status;
    logic [TIME_BITS-1:0] wr_time;
    logic [TIME_BITS-1:0] cmp_a;
    logic [TIME_BITS-1:0] cmp_b;
    cmp_res_t             cmp_res;

    assign in_cmd  = s_tdata[CMD_W-1:0];
    assign in_time = s_tdata[CMD_W+TIME_BITS-1:CMD_W];
    assign in_ver  = s_tdata[CMD_W+TIME_BITS+VER_W-1:CMD_W+TIME_BITS];
    assign m_tdata = {1'b0, out_ver, out_status};

    rvoc_seq #(
        .MAX_VERSIONS (MAX_VERSIONS),
        .TIME_BITS    (TIME_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (in_cmd),
        .in_time    (in_time),
        .in_ver     (in_ver),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_ver    (out_ver),
        .rd_addr    (rd_addr),
        .rd_status  (rd_status),
        .rd_wtime   (rd_wtime),
        .rd_rtime   (rd_rtime),
        .wr_ctrl    (wr_ctrl),
        .wr_addr    (wr_addr),
        .wr_status  (wr_status),
        .wr_time    (wr_time),
        .cmp_a      (cmp_a),
        .cmp_b      (cmp_b),
        .cmp_res    (cmp_res)
    );

    rvoc_store #(
        .MAX_VERSIONS (MAX_VERSIONS),
        .TIME_BITS    (TIME_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .rd_status (rd_status),
        .rd_wtime  (rd_wtime),
        .rd_rtime  (rd_rtime),
        .wr_ctrl   (wr_ctrl),
        .wr_addr   (wr_addr),
        .wr_status (wr_status),
        .wr_time   (wr_time)
    );

    rvoc_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

endmodule

### rtl/core/rvoc_checker.sv
module rvoc_checker
    import rvoc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata
);

    logic [STATUS_W-1:0] status;
    logic [VER_W-1:0]    ver;

    assign status = m_tdata[STATUS_W-1:0];
    assign ver    = m_tdata[STATUS_W+VER_W-1:STATUS_W];

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status == RES_OK || status == RES_WAIT || status == RES_ABORT
                      || status == RES_FULL || status == RES_BAD))
        else $error("result carries an unknown status code");

    a_ver_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status != RES_OK) |-> (ver == '0))
        else $error("failed result carries a nonzero version");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while previous one still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind row_version_order_checker rvoc_checker u_rvoc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/row_version_order_checker_tb.sv
module row_version_order_checker_tb;

    import rvoc_pkg::*;

    localparam int MAX_VERSIONS = 16;
    localparam int TIME_BITS    = 48;
    localparam int S_W          = ((CMD_W + TIME_BITS + VER_W + 7) / 8) * 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1350;

    localparam logic [CMD_W-1:0]     CMD_UNKNOWN = 3'd7;
    localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VER_W-1:0]    version_out;
    } reply_t;

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [7:0]     m_tdata;

    logic [ENTRY_W-1:0]   ver_status [MAX_VERSIONS];
    logic [TIME_BITS-1:0] ver_wtime  [MAX_VERSIONS];
    logic [TIME_BITS-1:0] ver_rtime  [MAX_VERSIONS];
    int unsigned          ver_count;

    reply_t               awaited_replies[$];
    int                   mismatch_count;
    int                   items_sent;
    int                   cycle_count;
    bit                   quiet;
    bit                   hold_req;
    logic [TIME_BITS-1:0] txn_clock;

    row_version_order_checker #(
        .MAX_VERSIONS(MAX_VERSIONS),
        .TIME_BITS   (TIME_BITS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // newest live version whose write time is not above t
    function automatic int unsigned find_visible(logic [TIME_BITS-1:0] t);
        int unsigned i;
        i = ver_count;
        while (i > 0)
        begin
            i--;
            if (ver_status[i] != ST_ABORTED && ver_wtime[i] <= t)
                return i;
        end
        return 0;
    endfunction

    function automatic int unsigned last_live();
        int unsigned i;
        i = ver_count;
        while (i > 0)
        begin
            i--;
            if (ver_status[i] != ST_ABORTED)
                return i;
        end
        return 0;
    endfunction

    function automatic reply_t apply_command(logic [CMD_W-1:0] cmd, logic [TIME_BITS-1:0] t,
                                             logic [VER_W-1:0] ver);
        reply_t      r;
        int unsigned v;
        int unsigned head;
        bit          id_ok;
        r.status      = RES_OK;
        r.version_out = '0;
        head          = ver_count - 1;
        id_ok         = int'(ver) < ver_count;
        case (cmd)
            CMD_READ:
            begin
                v = find_visible(t);
                if (ver_status[v] == ST_PENDING)
                    r.status = RES_WAIT;
                else
                    r.version_out = VER_W'(v);
            end
            CMD_READ_STAMP:
            begin
                if (!id_ok)
                    r.status = RES_BAD;
                else if (ver_rtime[ver] < t)
                    ver_rtime[ver] = t;
            end
            CMD_READ_CHECK:
            begin
                if (!id_ok)
                    r.status = RES_BAD;
                else if (find_visible(t) != ver)
                    r.status = RES_ABORT;
            end
            CMD_WRITE_INSERT:
            begin
                if (!id_ok)
                    r.status = RES_BAD;
                else if (last_live() > ver)
                    r.status = RES_ABORT;
                else if (ver_rtime[ver] > t)
                    r.status = RES_ABORT;
                else if (ver_count >= MAX_VERSIONS)
                    r.status = RES_FULL;
                else
                begin
                    ver_status[ver_count] = ST_PENDING;
                    ver_wtime[ver_count]  = t;
                    ver_rtime[ver_count]  = t;
                    r.version_out         = VER_W'(ver_count);
                    ver_count++;
                end
            end
            CMD_WRITE_CHECK:
            begin
                v = find_visible(t);
                if (ver_rtime[v] > t)
                    r.status = RES_ABORT;
            end
            CMD_COMMIT:
            begin
                if (ver_status[head] == ST_PENDING && ver_wtime[head] == t)
                    ver_status[head] = ST_COMMITTED;
                else
                    r.status = RES_BAD;
            end
            CMD_ABORT:
            begin
                if (ver_status[head] == ST_PENDING && ver_wtime[head] == t)
                    ver_status[head] = ST_ABORTED;
            end
            default:
                r.status = RES_BAD;
        endcase
        return r;
    endfunction

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [TIME_BITS-1:0] t,
                                logic [VER_W-1:0] ver);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({ver, t, cmd});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        awaited_replies.push_back(apply_command(cmd, t, ver));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic run_transaction();
        logic [TIME_BITS-1:0] t;
        logic [VER_W-1:0]     seen;
        txn_clock += $urandom_range(1, 16);
        t = txn_clock;
        if ($urandom_range(0, 7) == 0)
            t = txn_clock - $urandom_range(0, 60);
        send_command(CMD_READ, t, VER_W'($urandom_range(0, 15)));
        seen = VER_W'(find_visible(t));
        if ($urandom_range(0, 3) != 0)
            send_command(CMD_READ_STAMP, t, seen);
        if ($urandom_range(0, 2) == 0)
            send_command(CMD_READ_CHECK, t,
                         $urandom_range(0, 4) == 0 ? VER_W'($urandom_range(0, 15)) : seen);
        if ($urandom_range(0, 9) == 0)
        begin
            send_command(CMD_WRITE_CHECK, t, seen);
            send_command(CMD_WRITE_INSERT, t,
                         $urandom_range(0, 4) == 0 ? seen : VER_W'(last_live()));
            case ($urandom_range(0, 9))
                0: ;
                1, 2: send_command(CMD_ABORT, t, VER_W'($urandom_range(0, 15)));
                3: send_command(CMD_COMMIT, t + 1, VER_W'($urandom_range(0, 15)));
                default: send_command(CMD_COMMIT, t, VER_W'($urandom_range(0, 15)));
            endcase
        end
    endtask

    task automatic send_noise();
        logic [CMD_W-1:0]     cmd;
        logic [TIME_BITS-1:0] t;
        int unsigned          head;
        cmd  = CMD_W'($urandom_range(0, 7));
        head = ver_count - 1;
        t    = txn_clock + $urandom_range(0, 20) - 10;
        // keep stamps and inserts near the running clock so later inserts stay possible
        if (cmd != CMD_READ_STAMP && cmd != CMD_WRITE_INSERT && $urandom_range(0, 1) == 0)
            t = TIME_BITS'({$urandom, $urandom});
        if ($urandom_range(0, 2) == 0)
        begin
            cmd = $urandom_range(0, 1) == 0 ? CMD_COMMIT : CMD_ABORT;
            t   = ver_wtime[head];
        end
        send_command(cmd, t, VER_W'($urandom_range(0, 15)));
    endtask

    task automatic test_zero_time_version();
        send_command(CMD_READ, '0, '0);
        send_command(CMD_WRITE_INSERT, '0, '0);
        send_command(CMD_READ, '0, '0);
        send_command(CMD_ABORT, '0, '0);
        send_command(CMD_ABORT, '0, '0);
    endtask

    task automatic test_read_paths();
        send_command(CMD_READ, TIME_MAX, 4'd15);
        send_command(CMD_READ_STAMP, 48'd5, 4'd0);
        send_command(CMD_READ_CHECK, 48'd10, 4'd0);
        send_command(CMD_READ_CHECK, 48'd10, 4'd1);
        send_command(CMD_WRITE_INSERT, 48'd3, 4'd0);
        send_command(CMD_WRITE_CHECK, 48'd3, 4'd0);
        send_command(CMD_WRITE_CHECK, TIME_MAX, 4'd0);
    endtask

    task automatic test_commit_paths();
        send_command(CMD_WRITE_INSERT, 48'd20, 4'd0);
        send_command(CMD_READ, 48'd25, 4'd0);
        send_command(CMD_READ, 48'd19, 4'd0);
        send_command(CMD_COMMIT, 48'd21, 4'd0);
        send_command(CMD_COMMIT, 48'd20, 4'd0);
        send_command(CMD_COMMIT, 48'd20, 4'd0);
        send_command(CMD_WRITE_INSERT, 48'd30, 4'd0);
    endtask

    task automatic test_bad_requests();
        send_command(CMD_READ_STAMP, 48'd40, 4'd15);
        send_command(CMD_READ_CHECK, 48'd40, 4'd3);
        send_command(CMD_WRITE_INSERT, 48'd40, 4'd15);
        send_command(CMD_UNKNOWN, TIME_MAX, 4'd15);
        send_command(CMD_READ_STAMP, TIME_MAX, 4'd0);
    endtask

    task automatic test_random_traffic(int target);
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                run_transaction();
        end
    endtask

    task automatic test_output_backpressure();
        int i;
        hold_req = 1'b1;
        for (i = 0; i < 8; i++)
            run_transaction();
    endtask

    task automatic test_back_to_back(int transactions);
        int i;
        quiet = 1'b1;
        for (i = 0; i < transactions; i++)
            run_transaction();
        quiet = 1'b0;
    endtask

    initial
    begin : reply_sink
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : reply_check
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("unexpected result transfer: status %0d, version_out %0d",
                       m_tdata[2:0], m_tdata[6:3]);
                mismatch_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (m_tdata[2:0] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                    mismatch_count++;
                end
                if (m_tdata[6:3] !== want.version_out)
                begin
                    $error("version_out: expected %0d, got %0d", want.version_out, m_tdata[6:3]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int base;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        quiet          = 1'b0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        cycle_count    = 0;
        txn_clock      = 48'd100;
        for (int i = 0; i < MAX_VERSIONS; i++)
        begin
            ver_status[i] = ST_COMMITTED;
            ver_wtime[i]  = '0;
            ver_rtime[i]  = '0;
        end
        ver_count = 1;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_zero_time_version();
        test_read_paths();
        test_commit_paths();
        test_bad_requests();

        base = items_sent;
        test_random_traffic(base + RANDOM_ITEMS / 3);
        test_output_backpressure();
        test_back_to_back(40);
        test_random_traffic(base + (RANDOM_ITEMS * 2) / 3);
        test_output_backpressure();
        test_random_traffic(base + RANDOM_ITEMS);

        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
